>>> src/tksi_pkg.sv
`timescale 1ns / 1ps

package tksi_pkg;

  localparam int unsigned KCfgW        = 5;
  localparam int unsigned CountW       = 5;
  localparam logic [KCfgW-1:0] KReset  = 5'd8;

  localparam int unsigned MaxKDefault      = 16;
  localparam int unsigned DistBitsDefault  = 24;
  localparam int unsigned CoordBitsDefault = 12;

  typedef struct packed {
    logic in_list;
    logic left_lt;
  } cell_ctl_t;

endpackage

>>> src/tksi_cell.sv
`timescale 1ns / 1ps

module tksi_cell
  import tksi_pkg::*;
#(
  parameter int unsigned DIST_BITS  = DistBitsDefault,
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  cell_ctl_t             ctl_i,
  input  logic [DIST_BITS-1:0]  cand_distance_i,
  input  logic [COORD_BITS-1:0] cand_x_i,
  input  logic [COORD_BITS-1:0] cand_y_i,
  input  logic [DIST_BITS-1:0]  left_distance_i,
  input  logic [COORD_BITS-1:0] left_x_i,
  input  logic [COORD_BITS-1:0] left_y_i,
  output logic [DIST_BITS-1:0]  distance_o,
  output logic [COORD_BITS-1:0] x_o,
  output logic [COORD_BITS-1:0] y_o,
  output logic                  lt_o
);

  logic [DIST_BITS-1:0]  distance_q, distance_d;
  logic [COORD_BITS-1:0] x_q, x_d;
  logic [COORD_BITS-1:0] y_q, y_d;

  assign lt_o = ctl_i.in_list && (distance_q < cand_distance_i);

  always_comb begin
    priority if (lt_o) begin
      distance_d = distance_q;
      x_d        = x_q;
      y_d        = y_q;
    end else if (ctl_i.left_lt) begin
      distance_d = cand_distance_i;
      x_d        = cand_x_i;
      y_d        = cand_y_i;
    end else begin
      distance_d = left_distance_i;
      x_d        = left_x_i;
      y_d        = left_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      distance_q <= distance_d;
      x_q        <= x_d;
      y_q        <= y_d;
    end
  end

  assign distance_o = distance_q;
  assign x_o        = x_q;
  assign y_o        = y_q;

endmodule

>>> src/bounded_top_k_sorted_insert.sv
`timescale 1ns / 1ps

// Sorted list of the best candidate matches, held in a row of cells, one entry per cell.
// A command is a transfer at a rising edge with start_i high and busy_o low; busy_o is
// always low, so a new candidate may be issued in every cycle.
// Each cell compares its entry with the candidate, and all cells shift or load at once,
// so the next candidate may follow immediately.
// The result appears in the cycle after the command transfer, marked by done_o, which is
// high for exactly one cycle. The receiver cannot stall, so nothing is held back.
// start_new_list_i empties the list before the candidate is inserted.
// k_in_use_we_i writes k_in_use_i; zero acts as one and values above MAX_K saturate.
// Reset empties the list and sets k to eight; entry contents are not cleared.
module bounded_top_k_sorted_insert
  import tksi_pkg::*;
#(
  parameter int unsigned MAX_K      = MaxKDefault,
  parameter int unsigned DIST_BITS  = DistBitsDefault,
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  k_in_use_we_i,
  input  logic [KCfgW-1:0]      k_in_use_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  start_new_list_i,
  input  logic [DIST_BITS-1:0]  cand_distance_i,
  input  logic [COORD_BITS-1:0] cand_x_i,
  input  logic [COORD_BITS-1:0] cand_y_i,
  output logic                  done_o,
  output logic [DIST_BITS-1:0]  best_distance_o,
  output logic [COORD_BITS-1:0] best_x_o,
  output logic [COORD_BITS-1:0] best_y_o,
  output logic [CountW-1:0]     entry_count_o,
  output logic                  was_kept_o
);

  localparam int unsigned CntW = $clog2(MAX_K + 1);

  logic [KCfgW-1:0] k_in_use_q;
  logic [CntW-1:0]  k_eff;
  logic [CntW-1:0]  held_q, held_d;
  logic [CntW-1:0]  count;
  logic             go;
  logic             kept;
  logic             done_q;
  logic [CntW-1:0]  entry_count_q;
  logic             was_kept_q;

  logic [MAX_K-1:0]      lt;
  logic [MAX_K-1:0]      last_sel;
  cell_ctl_t             ctl      [MAX_K];
  logic [DIST_BITS-1:0]  cell_dist[MAX_K];
  logic [COORD_BITS-1:0] cell_x   [MAX_K];
  logic [COORD_BITS-1:0] cell_y   [MAX_K];

  assign busy_o = 1'b0;
  assign go     = start_i && !busy_o;

  always_comb begin
    priority if (k_in_use_q == '0) begin
      k_eff = CntW'(1);
    end else if (int'(k_in_use_q) > int'(MAX_K)) begin
      k_eff = CntW'(MAX_K);
    end else begin
      k_eff = CntW'(k_in_use_q);
    end
  end

  always_comb begin
    if (start_new_list_i) begin
      count = '0;
    end else if (held_q > k_eff) begin
      count = k_eff;
    end else begin
      count = held_q;
    end
  end

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    assign ctl[i].in_list = CntW'(i) < count;
    assign last_sel[i]    = CntW'(i + 1) == k_eff;
    if (i == 0) begin : g_head
      assign ctl[i].left_lt = 1'b1;
      tksi_cell #(
        .DIST_BITS (DIST_BITS),
        .COORD_BITS(COORD_BITS)
      ) u_cell (
        .clk_i          (clk_i),
        .load_i         (go),
        .ctl_i          (ctl[i]),
        .cand_distance_i(cand_distance_i),
        .cand_x_i       (cand_x_i),
        .cand_y_i       (cand_y_i),
        .left_distance_i(cand_distance_i),
        .left_x_i       (cand_x_i),
        .left_y_i       (cand_y_i),
        .distance_o     (cell_dist[i]),
        .x_o            (cell_x[i]),
        .y_o            (cell_y[i]),
        .lt_o           (lt[i])
      );
    end else begin : g_body
      assign ctl[i].left_lt = lt[i-1];
      tksi_cell #(
        .DIST_BITS (DIST_BITS),
        .COORD_BITS(COORD_BITS)
      ) u_cell (
        .clk_i          (clk_i),
        .load_i         (go),
        .ctl_i          (ctl[i]),
        .cand_distance_i(cand_distance_i),
        .cand_x_i       (cand_x_i),
        .cand_y_i       (cand_y_i),
        .left_distance_i(cell_dist[i-1]),
        .left_x_i       (cell_x[i-1]),
        .left_y_i       (cell_y[i-1]),
        .distance_o     (cell_dist[i]),
        .x_o            (cell_x[i]),
        .y_o            (cell_y[i]),
        .lt_o           (lt[i])
      );
    end
  end

  assign kept = ~|(lt & last_sel);

  always_comb begin
    if (kept && (count < k_eff)) begin
      held_d = count + CntW'(1);
    end else begin
      held_d = count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_in_use_q <= KReset;
      held_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      if (k_in_use_we_i) begin
        k_in_use_q <= k_in_use_i;
      end
      if (go) begin
        held_q <= held_d;
      end
      done_q <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      entry_count_q <= held_d;
      was_kept_q    <= kept;
    end
  end

  assign done_o          = done_q;
  assign best_distance_o = cell_dist[0];
  assign best_x_o        = cell_x[0];
  assign best_y_o        = cell_y[0];
  assign was_kept_o      = was_kept_q;

  if (CntW >= CountW) begin : g_cnt_trunc
    assign entry_count_o = entry_count_q[CountW-1:0];
  end else begin : g_cnt_ext
    assign entry_count_o = {{(CountW - CntW){1'b0}}, entry_count_q};
  end

endmodule

>>> tb/sv/bounded_top_k_sorted_insert_tb.sv
`timescale 1ns / 1ps

module bounded_top_k_sorted_insert_tb;
  import tksi_pkg::*;

  localparam int unsigned MaxK   = MaxKDefault;
  localparam int unsigned DistW  = DistBitsDefault;
  localparam int unsigned CoordW = CoordBitsDefault;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned RandomPhases = 10;

  typedef struct packed {
    logic              new_list;
    logic [DistW-1:0]  distance;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } candidate_t;

  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CountW-1:0] count;
    logic              kept;
  } head_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              k_in_use_we_i = 1'b0;
  logic [KCfgW-1:0]  k_in_use_i = '0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              start_new_list_i = 1'b0;
  logic [DistW-1:0]  cand_distance_i = '0;
  logic [CoordW-1:0] cand_x_i = '0;
  logic [CoordW-1:0] cand_y_i = '0;
  logic              done_o;
  logic [DistW-1:0]  best_distance_o;
  logic [CoordW-1:0] best_x_o;
  logic [CoordW-1:0] best_y_o;
  logic [CountW-1:0] entry_count_o;
  logic              was_kept_o;

  candidate_t   candidate_q[$];
  head_report_t head_report_q[$];
  int unsigned  n_queued = 0;
  int unsigned  n_reports = 0;
  int unsigned  n_mismatch = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  gap_pct = 18;
  logic         took_item = 1'b0;

  logic [KCfgW-1:0]  k_cfg = KReset;
  logic [DistW-1:0]  list_dist [MaxK] = '{default: '0};
  logic [CoordW-1:0] list_x [MaxK] = '{default: '0};
  logic [CoordW-1:0] list_y [MaxK] = '{default: '0};
  int unsigned       held_entries = 0;

  bounded_top_k_sorted_insert u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .k_in_use_we_i    (k_in_use_we_i),
    .k_in_use_i       (k_in_use_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .start_new_list_i (start_new_list_i),
    .cand_distance_i  (cand_distance_i),
    .cand_x_i         (cand_x_i),
    .cand_y_i         (cand_y_i),
    .done_o           (done_o),
    .best_distance_o  (best_distance_o),
    .best_x_o         (best_x_o),
    .best_y_o         (best_y_o),
    .entry_count_o    (entry_count_o),
    .was_kept_o       (was_kept_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned effective_k(input logic [KCfgW-1:0] k);
    if (k == 0) begin
      return 1;
    end
    return (k > MaxK) ? MaxK : k;
  endfunction

  function automatic head_report_t insert_candidate(input candidate_t c);
    head_report_t r;
    int unsigned  k_eff;
    int unsigned  cnt;
    int unsigned  pos;
    int unsigned  nc;
    int unsigned  i;
    logic         kept;
    k_eff = effective_k(k_cfg);
    if (c.new_list) begin
      held_entries = 0;
    end
    cnt = (held_entries > k_eff) ? k_eff : held_entries;
    pos = 0;
    while (pos < cnt && list_dist[pos] < c.distance) begin
      pos++;
    end
    kept = (pos < k_eff);
    if (kept) begin
      nc = (cnt + 1 > k_eff) ? k_eff : cnt + 1;
      for (i = nc - 1; i > pos; i--) begin
        list_dist[i] = list_dist[i-1];
        list_x[i]    = list_x[i-1];
        list_y[i]    = list_y[i-1];
      end
      list_dist[pos] = c.distance;
      list_x[pos]    = c.x;
      list_y[pos]    = c.y;
    end else begin
      nc = cnt;
    end
    held_entries = nc;
    r.distance = list_dist[0];
    r.x        = list_x[0];
    r.y        = list_y[0];
    r.count    = nc[CountW-1:0];
    r.kept     = kept;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      n_mismatch++;
    end
  endtask

  always @(negedge clk_i) begin
    candidate_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || took_item) begin
      if (candidate_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = candidate_q.pop_front();
        start_i          <= 1'b1;
        start_new_list_i <= nxt.new_list;
        cand_distance_i  <= nxt.distance;
        cand_x_i         <= nxt.x;
        cand_y_i         <= nxt.y;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    head_report_t want;
    candidate_t   c;
    logic         accepted;
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      if (done_o) begin
        if (head_report_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got distance %0d count %0d",
                   $time, best_distance_o, entry_count_o);
          n_mismatch++;
        end else begin
          want = head_report_q.pop_front();
          report_field("best_distance", 32'(want.distance), 32'(best_distance_o));
          report_field("best_x", 32'(want.x), 32'(best_x_o));
          report_field("best_y", 32'(want.y), 32'(best_y_o));
          report_field("entry_count", 32'(want.count), 32'(entry_count_o));
          report_field("was_kept", 32'(want.kept), 32'(was_kept_o));
          n_reports++;
        end
      end
      if (k_in_use_we_i) begin
        k_cfg = k_in_use_i;
      end
      if (accepted) begin
        c.new_list = start_new_list_i;
        c.distance = cand_distance_i;
        c.x        = cand_x_i;
        c.y        = cand_y_i;
        head_report_q = {head_report_q, insert_candidate(c)};
      end
      took_item <= accepted;
      if (accepted || done_o || k_in_use_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_candidate(input logic new_list, input logic [DistW-1:0] distance,
                                 input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    candidate_t c;
    c.new_list = new_list;
    c.distance = distance;
    c.x        = x;
    c.y        = y;
    candidate_q = {candidate_q, c};
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_reports != n_queued) begin
      @(negedge clk_i);
    end
  endtask

  task automatic set_k(input logic [KCfgW-1:0] k);
    wait_drained();
    @(negedge clk_i);
    k_in_use_we_i <= 1'b1;
    k_in_use_i    <= k;
    @(negedge clk_i);
    k_in_use_we_i <= 1'b0;
  endtask

  function automatic logic [DistW-1:0] pick_distance(input int unsigned mode);
    case (mode)
      0: return DistW'($urandom);
      1: return DistW'($urandom_range(15));
      default: begin
        case ($urandom_range(2))
          0: return '0;
          1: return '1;
          default: return DistW'($urandom);
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [KCfgW-1:0] k_val;
    int unsigned      made;
    int unsigned      run_len;
    int unsigned      mode;
    int unsigned      j;
    int unsigned      ph;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // The list starts empty after reset, so the first candidate needs no start flag.
    queue_candidate(1'b0, 24'd500, 12'd0, 12'd0);
    queue_candidate(1'b0, '1, '1, '1);
    queue_candidate(1'b0, '0, '1, '0);
    queue_candidate(1'b0, '0, 12'd1, 12'd2);
    queue_candidate(1'b0, 24'd500, 12'd7, 12'd7);
    queue_candidate(1'b0, 24'd300, 12'd8, 12'd8);
    queue_candidate(1'b0, 24'd700, 12'd9, 12'd9);
    queue_candidate(1'b0, '1, '0, '1);
    queue_candidate(1'b0, 24'd600, 12'd10, 12'd10);
    queue_candidate(1'b0, '1, 12'd5, 12'd5);
    queue_candidate(1'b1, 24'hAAAAAA, 12'h555, 12'hAAA);
    queue_candidate(1'b0, 24'h555555, 12'hAAA, 12'h555);

    // Lowering k below the held count trims the list at the next step.
    set_k(5'd2);
    queue_candidate(1'b0, 24'h800000, 12'd11, 12'd11);

    set_k(5'd1);
    queue_candidate(1'b1, 24'd50, 12'd1, 12'd1);
    queue_candidate(1'b0, 24'd50, 12'd2, 12'd2);
    queue_candidate(1'b0, 24'd51, 12'd3, 12'd3);
    queue_candidate(1'b0, '0, 12'd4, 12'd4);

    set_k(5'd0);
    queue_candidate(1'b0, 24'd10, 12'd5, 12'd5);
    queue_candidate(1'b0, 24'd10, 12'd6, 12'd6);
    queue_candidate(1'b1, '1, '1, '1);

    for (ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: k_val = 5'd31;
        1: k_val = 5'd16;
        2: k_val = 5'd17;
        3: k_val = 5'd1;
        default: k_val = ($urandom_range(4) == 0) ? KCfgW'($urandom_range(17, 31))
                                                  : KCfgW'($urandom_range(1, 16));
      endcase
      set_k(k_val);
      gap_pct = (ph == 5) ? 0 : 18;
      made = 0;
      while (made < ItemsPerPhase) begin
        run_len = $urandom_range(1, 2 * effective_k(k_val) + 4);
        mode = $urandom_range(3);
        for (j = 0; j < run_len; j++) begin
          if (j == 0) begin
            queue_candidate($urandom_range(9) != 0, pick_distance(mode),
                            CoordW'($urandom), CoordW'($urandom));
          end else begin
            queue_candidate($urandom_range(19) == 0, pick_distance(mode),
                            CoordW'($urandom), CoordW'($urandom));
          end
        end
        made += run_len;
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (n_mismatch == 0 && head_report_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
